FILE: sv/ptfa_pkg.sv
`default_nettype none

package ptfa_pkg;

  // field widths of the beats
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned VA_W       = 22;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned PPAGE_W    = 9;
  localparam int unsigned PA_W       = 20;

  // bitmaps are kept as words of this many page bits
  localparam int unsigned MAP_WORD_W = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_TRANSLATE = 2'd0,
    MODE_MAP       = 2'd1,
    MODE_ALLOC     = 2'd2,
    MODE_FREE      = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NOT_MAPPED = 2'd1,
    STATUS_NO_PHYS    = 2'd2,
    STATUS_NO_VIRT    = 2'd3
  } status_e;

  // source of the physical page reported in a result
  typedef enum logic [1:0] {
    PG_NONE  = 2'd0,
    PG_ENTRY = 2'd1,
    PG_FOUND = 2'd2
  } page_sel_e;

  // controller to datapath
  typedef struct packed {
    logic      clear;        // init sweep step
    logic      capture;      // latch input beat
    logic      rd_entry_va;  // read table entry at the input page
    logic      rd_vfree;     // read first virtual word with a free bit
    logic      vfree_take;   // take free virtual page, read its entry
    logic      rd_pfree;     // read first physical word with a free bit
    logic      vset;         // mark target virtual page used
    logic      map_commit;   // take free physical page, write entry
    logic      free_commit;  // clear entry and both bitmap bits
    logic      res_load;     // load result register
    status_e   res_status;
    page_sel_e res_page;
    logic      res_addr;     // report physical address
    logic      res_offset;   // include byte offset in address
    logic      res_rva;      // report allocated virtual address
    logic      load_out;     // move result into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic  clear_last;
    mode_e mode;
    logic  va_in_range;
    logic  phys_full;
    logic  virt_full;
    logic  entry_present;
  } stat_t;

endpackage

`default_nettype wire

FILE: sv/ptfa_ram.sv
`default_nettype none

module ptfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/ptfa_ctrl.sv
`default_nettype none

module ptfa_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  input  wire ptfa_pkg::stat_t stat_i,
  output ptfa_pkg::cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_VWORD,
    ST_ENTRY,
    ST_PWORD,
    ST_FREE,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;

    // output beat taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end

      ST_DECODE: begin
        if (stat_i.mode == ptfa_pkg::MODE_ALLOC) begin
          if (stat_i.phys_full) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ptfa_pkg::STATUS_NO_PHYS;
            state_d          = ST_EMIT;
          end else if (stat_i.virt_full) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ptfa_pkg::STATUS_NO_VIRT;
            state_d          = ST_EMIT;
          end else begin
            cmd_o.rd_vfree = 1'b1;
            state_d        = ST_VWORD;
          end
        end else if (!stat_i.va_in_range) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ptfa_pkg::STATUS_NOT_MAPPED;
          state_d          = ST_EMIT;
        end else begin
          cmd_o.rd_entry_va = 1'b1;
          state_d           = ST_ENTRY;
        end
      end

      ST_VWORD: begin
        cmd_o.vfree_take = 1'b1;
        state_d          = ST_ENTRY;
      end

      ST_ENTRY: begin
        case (stat_i.mode)
          ptfa_pkg::MODE_TRANSLATE: begin
            cmd_o.res_load = 1'b1;
            if (stat_i.entry_present) begin
              cmd_o.res_status = ptfa_pkg::STATUS_OK;
              cmd_o.res_page   = ptfa_pkg::PG_ENTRY;
              cmd_o.res_addr   = 1'b1;
              cmd_o.res_offset = 1'b1;
            end else begin
              cmd_o.res_status = ptfa_pkg::STATUS_NOT_MAPPED;
            end
            state_d = ST_EMIT;
          end
          ptfa_pkg::MODE_MAP: begin
            if (stat_i.entry_present) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ptfa_pkg::STATUS_OK;
              cmd_o.res_page   = ptfa_pkg::PG_ENTRY;
              cmd_o.res_addr   = 1'b1;
              cmd_o.res_offset = 1'b1;
              state_d          = ST_EMIT;
            end else if (stat_i.phys_full) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ptfa_pkg::STATUS_NO_PHYS;
              state_d          = ST_EMIT;
            end else begin
              cmd_o.rd_pfree = 1'b1;
              state_d        = ST_PWORD;
            end
          end
          ptfa_pkg::MODE_ALLOC: begin
            if (stat_i.entry_present) begin
              // page was mapped on demand earlier, keep it
              cmd_o.vset       = 1'b1;
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ptfa_pkg::STATUS_OK;
              cmd_o.res_page   = ptfa_pkg::PG_ENTRY;
              cmd_o.res_addr   = 1'b1;
              cmd_o.res_rva    = 1'b1;
              state_d          = ST_EMIT;
            end else begin
              cmd_o.rd_pfree = 1'b1;
              state_d        = ST_PWORD;
            end
          end
          ptfa_pkg::MODE_FREE: begin
            if (stat_i.entry_present) begin
              state_d = ST_FREE;
            end else begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ptfa_pkg::STATUS_NOT_MAPPED;
              state_d          = ST_EMIT;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_PWORD: begin
        cmd_o.map_commit = 1'b1;
        cmd_o.vset       = (stat_i.mode == ptfa_pkg::MODE_ALLOC);
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = ptfa_pkg::STATUS_OK;
        cmd_o.res_page   = ptfa_pkg::PG_FOUND;
        cmd_o.res_addr   = 1'b1;
        cmd_o.res_offset = (stat_i.mode == ptfa_pkg::MODE_MAP);
        cmd_o.res_rva    = (stat_i.mode == ptfa_pkg::MODE_ALLOC);
        state_d          = ST_EMIT;
      end

      ST_FREE: begin
        cmd_o.free_commit = 1'b1;
        cmd_o.res_load    = 1'b1;
        cmd_o.res_status  = ptfa_pkg::STATUS_OK;
        cmd_o.res_page    = ptfa_pkg::PG_ENTRY;
        state_d           = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: sv/ptfa_dp.sv
`default_nettype none

module ptfa_dp #(
  parameter int unsigned PAGE_SHIFT     = 12,
  parameter int unsigned VIRT_PAGES     = 1024,
  parameter int unsigned PHYS_PAGES     = 256,
  parameter int unsigned RESERVED_PAGES = 33
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [ptfa_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [ptfa_pkg::VA_W-1:0]     virtual_address_i,
  input  wire ptfa_pkg::cmd_t                cmd_i,
  output ptfa_pkg::stat_t                    stat_o,
  output logic      [ptfa_pkg::STATUS_W-1:0] status_o,
  output logic      [ptfa_pkg::PPAGE_W-1:0]  physical_page_o,
  output logic      [ptfa_pkg::PA_W-1:0]     physical_address_o,
  output logic      [ptfa_pkg::VA_W-1:0]     result_virtual_address_o
);

  localparam int unsigned VA_W      = ptfa_pkg::VA_W;
  localparam int unsigned PA_W      = ptfa_pkg::PA_W;
  localparam int unsigned PPAGE_W   = ptfa_pkg::PPAGE_W;
  localparam int unsigned WORD_W    = ptfa_pkg::MAP_WORD_W;
  localparam int unsigned BIT_W     = $clog2(WORD_W);
  localparam int unsigned VWORDS    = (VIRT_PAGES + WORD_W - 1) / WORD_W;
  localparam int unsigned PWORDS    = (PHYS_PAGES + WORD_W - 1) / WORD_W;
  localparam int unsigned VI_W      = $clog2(VIRT_PAGES);
  localparam int unsigned VW_W      = $clog2(VWORDS);
  localparam int unsigned PW_W      = $clog2(PWORDS);
  localparam int unsigned PPN_W     = $clog2(PHYS_PAGES + 1);
  localparam int unsigned ENT_W     = PPN_W + 1;
  localparam int unsigned VPG_W     = VA_W - PAGE_SHIFT;
  localparam int unsigned PA_FULL_W = PPN_W + PAGE_SHIFT;
  localparam int unsigned CLR_N     = (VIRT_PAGES > PWORDS) ? VIRT_PAGES : PWORDS;
  localparam int unsigned CLR_W     = $clog2(CLR_N);

  // virtual word after reset: bits past the last page read as used
  function automatic logic [WORD_W-1:0] vword_init(input logic [31:0] w);
    logic [WORD_W-1:0] word;
    logic [31:0]       idx;
    word = '0;
    for (int b = 0; b < WORD_W; b++) begin
      idx     = (w << BIT_W) + 32'(b);
      word[b] = (idx >= VIRT_PAGES);
    end
    return word;
  endfunction

  // physical word after reset: table pages and bits past the last page used
  function automatic logic [WORD_W-1:0] pword_init(input logic [31:0] w);
    logic [WORD_W-1:0] word;
    logic [31:0]       idx;
    word = '0;
    for (int b = 0; b < WORD_W; b++) begin
      idx     = (w << BIT_W) + 32'(b);
      word[b] = (idx < RESERVED_PAGES) || (idx >= PHYS_PAGES);
    end
    return word;
  endfunction

  ptfa_pkg::mode_e    mode_q;
  logic [VA_W-1:0]    va_q;
  logic [VI_W-1:0]    tgt_q, tgt_d;
  logic [WORD_W-1:0]  vword_q;
  logic [VWORDS-1:0]  vsum_q;
  logic [PWORDS-1:0]  psum_q;
  logic [CLR_W-1:0]   clr_cnt_q;

  logic [ptfa_pkg::STATUS_W-1:0] res_status_q, out_status_q;
  logic [PPAGE_W-1:0]            res_ppage_q, out_ppage_q;
  logic [PA_W-1:0]               res_pa_q, out_pa_q;
  logic [VA_W-1:0]               res_rva_q, out_rva_q;

  logic [VPG_W-1:0]      va_pg;
  logic [PAGE_SHIFT-1:0] va_off;
  logic                  va_in_range;

  logic [ENT_W-1:0]  ent_rdata, ent_wdata;
  logic [VI_W-1:0]   ent_waddr;
  logic              ent_we;
  logic [WORD_W-1:0] vw_rdata, vw_wdata, pw_rdata, pw_wdata;
  logic [VW_W-1:0]   vw_raddr, vw_waddr;
  logic [PW_W-1:0]   pw_raddr, pw_waddr;
  logic              vw_we, pw_we;

  logic [VW_W-1:0]   vsum_first;
  logic [PW_W-1:0]   psum_first;
  logic [BIT_W-1:0]  vbit_first, pbit_first;
  logic [VI_W-1:0]   v_found;
  logic [PPN_W-1:0]  p_found;

  logic              ent_present;
  logic [PPN_W-1:0]  ent_page, ent_pm1;
  logic [PW_W-1:0]   ent_pword;
  logic [BIT_W-1:0]  ent_pbit;
  logic [VW_W-1:0]   tgt_word;
  logic [BIT_W-1:0]  tgt_bit;
  logic [WORD_W-1:0] vmask, pmask_found, pmask_ent;

  logic [PPN_W-1:0]     res_pg, res_pm1;
  logic [PA_FULL_W-1:0] pa_full;

  // input page split
  assign va_pg       = va_q[VA_W-1:PAGE_SHIFT];
  assign va_off      = va_q[PAGE_SHIFT-1:0];
  assign va_in_range = (32'(va_pg) < VIRT_PAGES);

  // first word with a free bit, from the summary flags
  always_comb begin
    vsum_first = '0;
    for (int i = VWORDS - 1; i >= 0; i--) begin
      if (!vsum_q[i]) begin
        vsum_first = VW_W'(i);
      end
    end
  end

  always_comb begin
    psum_first = '0;
    for (int i = PWORDS - 1; i >= 0; i--) begin
      if (!psum_q[i]) begin
        psum_first = PW_W'(i);
      end
    end
  end

  // first free bit inside the fetched words
  always_comb begin
    vbit_first = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!vw_rdata[i]) begin
        vbit_first = BIT_W'(i);
      end
    end
  end

  always_comb begin
    pbit_first = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!pw_rdata[i]) begin
        pbit_first = BIT_W'(i);
      end
    end
  end

  assign v_found = VI_W'({vsum_first, vbit_first});
  assign p_found = PPN_W'({psum_first, pbit_first}) + PPN_W'(1);

  // table entry fields and bitmap positions
  assign ent_present = ent_rdata[PPN_W];
  assign ent_page    = ent_rdata[PPN_W-1:0];
  assign ent_pm1     = ent_page - PPN_W'(1);
  assign ent_pword   = PW_W'(ent_pm1 >> BIT_W);
  assign ent_pbit    = ent_pm1[BIT_W-1:0];
  assign tgt_word    = VW_W'(tgt_q >> BIT_W);
  assign tgt_bit     = tgt_q[BIT_W-1:0];
  assign vmask       = WORD_W'(1) << tgt_bit;
  assign pmask_found = WORD_W'(1) << pbit_first;
  assign pmask_ent   = WORD_W'(1) << ent_pbit;

  // target virtual page
  always_comb begin
    tgt_d = tgt_q;
    if (cmd_i.rd_entry_va) begin
      tgt_d = VI_W'(va_pg);
    end else if (cmd_i.vfree_take) begin
      tgt_d = v_found;
    end
  end

  // read addresses
  assign vw_raddr = cmd_i.rd_vfree ? vsum_first : tgt_word;
  assign pw_raddr = cmd_i.rd_pfree ? psum_first : ent_pword;

  // table writes
  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = tgt_q;
    ent_wdata = '0;
    if (cmd_i.clear) begin
      ent_we    = (32'(clr_cnt_q) < VIRT_PAGES);
      ent_waddr = VI_W'(clr_cnt_q);
    end else if (cmd_i.map_commit) begin
      ent_we    = 1'b1;
      ent_wdata = {1'b1, p_found};
    end else if (cmd_i.free_commit) begin
      ent_we    = 1'b1;
    end
  end

  // virtual bitmap writes
  always_comb begin
    vw_we    = 1'b0;
    vw_waddr = tgt_word;
    vw_wdata = vword_q | vmask;
    if (cmd_i.clear) begin
      vw_we    = (32'(clr_cnt_q) < VWORDS);
      vw_waddr = VW_W'(clr_cnt_q);
      vw_wdata = vword_init(32'(clr_cnt_q));
    end else if (cmd_i.vset) begin
      vw_we    = 1'b1;
    end else if (cmd_i.free_commit) begin
      vw_we    = 1'b1;
      vw_wdata = vw_rdata & ~vmask;
    end
  end

  // physical bitmap writes
  always_comb begin
    pw_we    = 1'b0;
    pw_waddr = psum_first;
    pw_wdata = pw_rdata | pmask_found;
    if (cmd_i.clear) begin
      pw_we    = (32'(clr_cnt_q) < PWORDS);
      pw_waddr = PW_W'(clr_cnt_q);
      pw_wdata = pword_init(32'(clr_cnt_q));
    end else if (cmd_i.map_commit) begin
      pw_we    = 1'b1;
    end else if (cmd_i.free_commit) begin
      pw_we    = 1'b1;
      pw_waddr = ent_pword;
      pw_wdata = pw_rdata & ~pmask_ent;
    end
  end

  ptfa_ram #(
    .WIDTH(ENT_W),
    .DEPTH(VIRT_PAGES)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(ent_waddr),
    .wdata_i(ent_wdata),
    .raddr_i(tgt_d),
    .rdata_o(ent_rdata)
  );

  ptfa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(VWORDS)
  ) u_vmap_ram (
    .clk_i  (clk_i),
    .we_i   (vw_we),
    .waddr_i(vw_waddr),
    .wdata_i(vw_wdata),
    .raddr_i(vw_raddr),
    .rdata_o(vw_rdata)
  );

  ptfa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(PWORDS)
  ) u_pmap_ram (
    .clk_i  (clk_i),
    .we_i   (pw_we),
    .waddr_i(pw_waddr),
    .wdata_i(pw_wdata),
    .raddr_i(pw_raddr),
    .rdata_o(pw_rdata)
  );

  // word-full summaries and init sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VWORDS; i++) begin
        vsum_q[i] <= (vword_init(32'(i)) == '1);
      end
      for (int i = 0; i < PWORDS; i++) begin
        psum_q[i] <= (pword_init(32'(i)) == '1);
      end
      clr_cnt_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + CLR_W'(1);
      end
      if (cmd_i.vset) begin
        vsum_q[tgt_word] <= &vw_wdata;
      end else if (cmd_i.free_commit) begin
        vsum_q[tgt_word] <= 1'b0;
      end
      if (cmd_i.map_commit) begin
        psum_q[psum_first] <= &pw_wdata;
      end else if (cmd_i.free_commit) begin
        psum_q[ent_pword] <= 1'b0;
      end
    end
  end

  // result fields
  always_comb begin
    case (cmd_i.res_page)
      ptfa_pkg::PG_ENTRY: res_pg = ent_page;
      ptfa_pkg::PG_FOUND: res_pg = p_found;
      default:            res_pg = '0;
    endcase
  end

  assign res_pm1 = res_pg - PPN_W'(1);
  assign pa_full = (PA_FULL_W'(res_pm1) << PAGE_SHIFT)
                 | PA_FULL_W'(cmd_i.res_offset ? va_off : '0);

  // input beat, search scratch and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= ptfa_pkg::mode_e'(mode_i);
      va_q   <= virtual_address_i;
    end
    tgt_q <= tgt_d;
    if (cmd_i.vfree_take) begin
      vword_q <= vw_rdata;
    end
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_ppage_q  <= PPAGE_W'(res_pg);
      res_pa_q     <= cmd_i.res_addr ? PA_W'(pa_full) : '0;
      res_rva_q    <= cmd_i.res_rva ?
                      VA_W'({tgt_q, {PAGE_SHIFT{1'b0}}}) : '0;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_ppage_q  <= res_ppage_q;
      out_pa_q     <= res_pa_q;
      out_rva_q    <= res_rva_q;
    end
  end

  // status toward the controller
  assign stat_o.clear_last    = (clr_cnt_q == CLR_W'(CLR_N - 1));
  assign stat_o.mode          = mode_q;
  assign stat_o.va_in_range   = va_in_range;
  assign stat_o.phys_full     = &psum_q;
  assign stat_o.virt_full     = &vsum_q;
  assign stat_o.entry_present = ent_present;

  assign status_o                 = out_status_q;
  assign physical_page_o          = out_ppage_q;
  assign physical_address_o       = out_pa_q;
  assign result_virtual_address_o = out_rva_q;

endmodule

`default_nettype wire

FILE: sv/page_table_frame_allocator_unit.sv
// channel  handshake               fields
// in       in_valid_i / in_stall_o  mode_i, virtual_address_i
// out      out_valid_o / out_stall_i status_o, physical_page_o, physical_address_o,
//                                   result_virtual_address_o
//
// one item at a time; after decode an item makes the registered ram reads that its mode
// needs: translate, map and free of a page in the table read its entry, map of a new page
// then a physical word, free then clears the entry and both bitmap bits; allocate reads a
// free virtual word, then its entry, then a physical word when that page has no entry yet
// after reset the page table and bitmap rams are swept once, with in_stall_o high
// a finished result waits in an output register; the next item is accepted meanwhile,
// and its last step holds for as long as that register still holds a stalled beat
`default_nettype none

module page_table_frame_allocator_unit #(
  parameter int unsigned PAGE_SHIFT     = 12,
  parameter int unsigned VIRT_PAGES     = 1024,
  parameter int unsigned PHYS_PAGES     = 256,
  parameter int unsigned RESERVED_PAGES = 33
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [ptfa_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [ptfa_pkg::VA_W-1:0]     virtual_address_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [ptfa_pkg::STATUS_W-1:0] status_o,
  output logic      [ptfa_pkg::PPAGE_W-1:0]  physical_page_o,
  output logic      [ptfa_pkg::PA_W-1:0]     physical_address_o,
  output logic      [ptfa_pkg::VA_W-1:0]     result_virtual_address_o
);

  ptfa_pkg::cmd_t  cmd;
  ptfa_pkg::stat_t stat;

  // sequencer
  ptfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // page table, bitmaps and result registers
  ptfa_dp #(
    .PAGE_SHIFT    (PAGE_SHIFT),
    .VIRT_PAGES    (VIRT_PAGES),
    .PHYS_PAGES    (PHYS_PAGES),
    .RESERVED_PAGES(RESERVED_PAGES)
  ) u_dp (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .mode_i                  (mode_i),
    .virtual_address_i       (virtual_address_i),
    .cmd_i                   (cmd),
    .stat_o                  (stat),
    .status_o                (status_o),
    .physical_page_o         (physical_page_o),
    .physical_address_o      (physical_address_o),
    .result_virtual_address_o(result_virtual_address_o)
  );

  // an accepted beat closes the input until its result is out
  a_accept_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input still open after accept");

  // a new mapping is only made over an absent entry
  a_map_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.map_commit |-> !stat.entry_present)
    else $error("mapping over a present entry");

  // a free only clears a present entry
  a_free_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.free_commit |-> stat.entry_present)
    else $error("free of an absent entry");

  // a result never overwrites a stalled output beat
  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || !out_stall_i))
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

FILE: tb/ptfa_checker.sv
module ptfa_checker #(
  parameter int unsigned PAGE_SHIFT     = 12,
  parameter int unsigned VIRT_PAGES     = 1024,
  parameter int unsigned PHYS_PAGES     = 256,
  parameter int unsigned RESERVED_PAGES = 33
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_i,
  input  wire logic [ptfa_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [ptfa_pkg::VA_W-1:0]     virtual_address_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_stall_i,
  input  wire logic [ptfa_pkg::STATUS_W-1:0] status_i,
  input  wire logic [ptfa_pkg::PPAGE_W-1:0]  physical_page_i,
  input  wire logic [ptfa_pkg::PA_W-1:0]     physical_address_i,
  input  wire logic [ptfa_pkg::VA_W-1:0]     result_virtual_address_i,
  output int unsigned                        pending_o,
  output int unsigned                        mismatch_count_o,
  output int unsigned                        checked_o,
  output int unsigned                        exhausted_o
);

  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned VA_W         = ptfa_pkg::VA_W;
  localparam int unsigned PA_W         = ptfa_pkg::PA_W;
  localparam int unsigned PPAGE_W      = ptfa_pkg::PPAGE_W;

  // one result beat, fields in port order
  typedef struct packed {
    ptfa_pkg::status_e   status;
    logic [PPAGE_W-1:0]  page;
    logic [PA_W-1:0]     paddr;
    logic [VA_W-1:0]     vaddr;
  } translation_t;

  // shadow of the page table and both bitmaps
  bit           entry_valid [VIRT_PAGES];
  int unsigned  entry_frame [VIRT_PAGES];
  bit           frame_busy  [PHYS_PAGES];
  bit           vpage_owned [VIRT_PAGES];

  translation_t pending_translations [$];

  // one-based lowest free frame, 0 when the pool is empty
  function automatic int unsigned lowest_free_frame();
    for (int unsigned i = 0; i < PHYS_PAGES; i++) begin
      if (!frame_busy[i]) return i + 1;
    end
    return 0;
  endfunction

  function automatic int unsigned lowest_free_vpage();
    for (int unsigned i = 0; i < VIRT_PAGES; i++) begin
      if (!vpage_owned[i]) return i + 1;
    end
    return 0;
  endfunction

  function automatic logic [PA_W-1:0] frame_base(input int unsigned frame);
    logic [63:0] wide;
    wide = 64'(frame - 1) << PAGE_SHIFT;
    return wide[PA_W-1:0];
  endfunction

  // existing frame if present, otherwise take the lowest free one
  function automatic int unsigned map_on_demand(input int unsigned vidx);
    int unsigned frame;
    if (entry_valid[vidx]) return entry_frame[vidx];
    frame = lowest_free_frame();
    if (frame == 0) return 0;
    frame_busy[frame - 1] = 1'b1;
    entry_valid[vidx]     = 1'b1;
    entry_frame[vidx]     = frame;
    return frame;
  endfunction

  // apply one request to the shadow state and give its result
  function automatic translation_t resolve_request(input ptfa_pkg::mode_e op,
                                                   input logic [VA_W-1:0] va);
    int unsigned  vidx;
    int unsigned  offs;
    int unsigned  frame;
    int unsigned  vfree;
    logic [63:0]  wide;
    translation_t r;
    vidx     = 32'(va) >> PAGE_SHIFT;
    offs     = 32'(va) & ((1 << PAGE_SHIFT) - 1);
    r        = '0;
    r.status = ptfa_pkg::STATUS_OK;
    if (op == ptfa_pkg::MODE_ALLOC) begin
      // physical pool is checked before the virtual one
      if (lowest_free_frame() == 0) begin
        r.status = ptfa_pkg::STATUS_NO_PHYS;
      end else begin
        vfree = lowest_free_vpage();
        if (vfree == 0) begin
          r.status = ptfa_pkg::STATUS_NO_VIRT;
        end else begin
          frame = map_on_demand(vfree - 1);
          vpage_owned[vfree - 1] = 1'b1;
          wide    = 64'(vfree - 1) << PAGE_SHIFT;
          r.page  = frame[PPAGE_W-1:0];
          r.paddr = frame_base(frame);
          r.vaddr = wide[VA_W-1:0];
        end
      end
    end else if (vidx >= VIRT_PAGES) begin
      r.status = ptfa_pkg::STATUS_NOT_MAPPED;
    end else begin
      case (op)
        ptfa_pkg::MODE_TRANSLATE: begin
          if (entry_valid[vidx]) begin
            frame   = entry_frame[vidx];
            r.page  = frame[PPAGE_W-1:0];
            r.paddr = frame_base(frame) | offs[PA_W-1:0];
          end else begin
            r.status = ptfa_pkg::STATUS_NOT_MAPPED;
          end
        end
        ptfa_pkg::MODE_MAP: begin
          // map leaves the virtual ownership bitmap alone
          frame = map_on_demand(vidx);
          if (frame == 0) begin
            r.status = ptfa_pkg::STATUS_NO_PHYS;
          end else begin
            r.page  = frame[PPAGE_W-1:0];
            r.paddr = frame_base(frame) | offs[PA_W-1:0];
          end
        end
        default: begin
          if (entry_valid[vidx]) begin
            frame = entry_frame[vidx];
            if (frame >= 1 && frame <= PHYS_PAGES) frame_busy[frame - 1] = 1'b0;
            vpage_owned[vidx] = 1'b0;
            entry_valid[vidx] = 1'b0;
            entry_frame[vidx] = 0;
            r.page            = frame[PPAGE_W-1:0];
          end else begin
            r.status = ptfa_pkg::STATUS_NOT_MAPPED;
          end
        end
      endcase
    end
    return r;
  endfunction

  task automatic note_failure(input string what);
    if (mismatch_count_o < REPORT_LIMIT) $display("ptfa check: %s", what);
    mismatch_count_o++;
  endtask

  // compare result beats first, then predict the request beat of this edge
  always @(posedge clk_i or negedge rst_ni) begin
    translation_t got;
    translation_t want;
    translation_t fresh;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < VIRT_PAGES; i++) begin
        entry_valid[i] = 1'b0;
        entry_frame[i] = 0;
        vpage_owned[i] = 1'b0;
      end
      for (int unsigned i = 0; i < PHYS_PAGES; i++) begin
        frame_busy[i] = (i < RESERVED_PAGES);
      end
      pending_translations.delete();
      pending_o        = 0;
      mismatch_count_o = 0;
      checked_o        = 0;
      exhausted_o      = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = {status_i, physical_page_i, physical_address_i, result_virtual_address_i};
        if (pending_translations.size() == 0) begin
          note_failure($sformatf("unexpected result status %0d page %0d pa %h va %h",
                                 got.status, got.page, got.paddr, got.vaddr));
        end else begin
          want = pending_translations.pop_front();
          checked_o++;
          if (got.status !== want.status || got.page !== want.page ||
              got.paddr !== want.paddr || got.vaddr !== want.vaddr) begin
            note_failure($sformatf(
              "result %0d expected status %0d page %0d pa %h va %h, got %0d %0d %h %h",
              checked_o, want.status, want.page, want.paddr, want.vaddr,
              got.status, got.page, got.paddr, got.vaddr));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        fresh = resolve_request(ptfa_pkg::mode_e'(mode_i), virtual_address_i);
        if (fresh.status == ptfa_pkg::STATUS_NO_PHYS) exhausted_o++;
        pending_translations.push_back(fresh);
      end
      pending_o = pending_translations.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
module tb_top;

  localparam int unsigned PAGE_SHIFT     = 12;
  localparam int unsigned VIRT_PAGES     = 1024;
  localparam int unsigned PHYS_PAGES     = 256;
  localparam int unsigned RESERVED_PAGES = 33;

  localparam int unsigned MODE_W   = ptfa_pkg::MODE_W;
  localparam int unsigned VA_W     = ptfa_pkg::VA_W;
  localparam int unsigned STATUS_W = ptfa_pkg::STATUS_W;
  localparam int unsigned PPAGE_W  = ptfa_pkg::PPAGE_W;
  localparam int unsigned PA_W     = ptfa_pkg::PA_W;

  localparam int unsigned HALF_PERIOD     = 5;
  localparam int unsigned ITEMS_PER_PHASE = 500;
  localparam int unsigned BURST_LEN       = 40;
  localparam int unsigned CHURN_PAGES     = 64;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned WATCHDOG_LIMIT  = 20000;

  // kinds of random request runs
  typedef enum int unsigned {
    RUN_FILL,
    RUN_DRAIN,
    RUN_CHURN,
    RUN_NOISE
  } run_kind_e;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [MODE_W-1:0]   mode      = ptfa_pkg::MODE_TRANSLATE;
  logic [VA_W-1:0]     vaddr     = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [PPAGE_W-1:0]  ppage;
  logic [PA_W-1:0]     paddr;
  logic [VA_W-1:0]     result_vaddr;

  int unsigned send_idle_pct = 25;
  int unsigned stall_pct     = 62;
  int unsigned fill_page     = 0;
  int unsigned drain_page    = 0;
  int unsigned requests_sent = 0;
  int unsigned idle_cycles   = 0;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned checked;
  int unsigned exhausted;

  page_table_frame_allocator_unit #(
    .PAGE_SHIFT     (PAGE_SHIFT),
    .VIRT_PAGES     (VIRT_PAGES),
    .PHYS_PAGES     (PHYS_PAGES),
    .RESERVED_PAGES (RESERVED_PAGES)
  ) dut (
    .clk_i                    (clk),
    .rst_ni                   (rst_n),
    .in_valid_i               (in_valid),
    .in_stall_o               (in_stall),
    .mode_i                   (mode),
    .virtual_address_i        (vaddr),
    .out_valid_o              (out_valid),
    .out_stall_i              (out_stall),
    .status_o                 (status),
    .physical_page_o          (ppage),
    .physical_address_o       (paddr),
    .result_virtual_address_o (result_vaddr)
  );

  ptfa_checker #(
    .PAGE_SHIFT     (PAGE_SHIFT),
    .VIRT_PAGES     (VIRT_PAGES),
    .PHYS_PAGES     (PHYS_PAGES),
    .RESERVED_PAGES (RESERVED_PAGES)
  ) checker_i (
    .clk_i                    (clk),
    .rst_ni                   (rst_n),
    .in_valid_i               (in_valid),
    .in_stall_i               (in_stall),
    .mode_i                   (mode),
    .virtual_address_i        (vaddr),
    .out_valid_i              (out_valid),
    .out_stall_i              (out_stall),
    .status_i                 (status),
    .physical_page_i          (ppage),
    .physical_address_i       (paddr),
    .result_virtual_address_i (result_vaddr),
    .pending_o                (pending),
    .mismatch_count_o         (mismatches),
    .checked_o                (checked),
    .exhausted_o              (exhausted)
  );

  always #HALF_PERIOD clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // no beat on either channel for too long ends the run
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               idle_cycles, pending);
      $display("page_table_frame_allocator_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one request beat, with random gaps in front of it
  task automatic send_request(input ptfa_pkg::mode_e op, input logic [VA_W-1:0] va);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= op;
    vaddr    <= va;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  // hold off the sender until every result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // field extremes, every mode, remap of a freed frame, alloc onto a mapped page
  task automatic run_directed();
    send_request(ptfa_pkg::MODE_TRANSLATE, 22'h000000);
    send_request(ptfa_pkg::MODE_FREE,      22'h3FFFFF);
    send_request(ptfa_pkg::MODE_MAP,       22'h000FFF);
    send_request(ptfa_pkg::MODE_TRANSLATE, 22'h000000);
    send_request(ptfa_pkg::MODE_MAP,       22'h000ABC);
    send_request(ptfa_pkg::MODE_ALLOC,     22'h3FFFFF);
    send_request(ptfa_pkg::MODE_ALLOC,     22'h000000);
    send_request(ptfa_pkg::MODE_MAP,       22'h3FFFFF);
    send_request(ptfa_pkg::MODE_TRANSLATE, 22'h3FFFFF);
    send_request(ptfa_pkg::MODE_FREE,      22'h3FF000);
    send_request(ptfa_pkg::MODE_TRANSLATE, 22'h3FFABC);
    send_request(ptfa_pkg::MODE_FREE,      22'h000123);
    send_request(ptfa_pkg::MODE_MAP,       22'h2AAAAA);
    send_request(ptfa_pkg::MODE_ALLOC,     22'h155555);
    send_request(ptfa_pkg::MODE_TRANSLATE, 22'h000FFF);
    send_request(ptfa_pkg::MODE_FREE,      22'h001000);
    send_request(ptfa_pkg::MODE_MAP,       22'h155555);
    send_request(ptfa_pkg::MODE_TRANSLATE, 22'h155555);
    send_request(ptfa_pkg::MODE_FREE,      22'h2AAAAA);
    send_request(ptfa_pkg::MODE_FREE,      22'h2AAAAA);
  endtask

  // bursts: sequential fill to exhaustion, sequential drain, churn, raw noise
  task automatic run_random(input int unsigned count);
    run_kind_e             kind;
    int unsigned           roll;
    int unsigned           vpage;
    logic [PAGE_SHIFT-1:0] offset;
    logic [VA_W-1:0]       va;
    ptfa_pkg::mode_e       op;
    kind = RUN_NOISE;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % BURST_LEN == 0) kind = run_kind_e'($urandom_range(0, 3));
      roll = $urandom_range(0, 99);
      case (kind)
        RUN_FILL: begin
          vpage     = fill_page;
          fill_page = (fill_page + 1) % VIRT_PAGES;
          op = (roll < 85) ? ptfa_pkg::MODE_MAP :
               ((roll < 95) ? ptfa_pkg::MODE_ALLOC : ptfa_pkg::MODE_TRANSLATE);
        end
        RUN_DRAIN: begin
          vpage      = drain_page;
          drain_page = (drain_page + 1) % VIRT_PAGES;
          op = (roll < 85) ? ptfa_pkg::MODE_FREE : ptfa_pkg::MODE_TRANSLATE;
        end
        RUN_CHURN: begin
          vpage = $urandom_range(0, CHURN_PAGES - 1);
          op    = ptfa_pkg::mode_e'($urandom_range(0, 3));
        end
        default: begin
          vpage = 0;
          op    = ptfa_pkg::mode_e'($urandom_range(0, 3));
        end
      endcase
      // offsets lean on their extremes now and then
      case ($urandom_range(0, 7))
        0:       offset = '0;
        1:       offset = '1;
        default: offset = PAGE_SHIFT'($urandom);
      endcase
      if (kind == RUN_NOISE) begin
        va = VA_W'($urandom);
      end else begin
        va = VA_W'(vpage << PAGE_SHIFT);
        va[PAGE_SHIFT-1:0] = offset;
      end
      send_request(op, va);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // sender sparse-ish, receiver stalling most of the time
    run_directed();
    wait_for_results();
    run_random(ITEMS_PER_PHASE);
    wait_for_results();

    // sender mostly idle, receiver mostly ready
    send_idle_pct = 62;
    stall_pct     = 25;
    run_random(ITEMS_PER_PHASE);
    wait_for_results();

    // back to back on both sides
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random(ITEMS_PER_PHASE);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests across all four modes under three gap/stall mixes",
             requests_sent);
    $display("%0d results checked, %0d of them hit an exhausted frame pool",
             checked, exhausted);
    if (mismatches == 0) begin
      $display("page_table_frame_allocator_unit: match");
    end else begin
      $display("page_table_frame_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule
